// File: rtl/core/egsa_pkg.sv
package egsa_pkg;

  localparam int DEF_MAX_ROWS = 1024;
  localparam int DEF_MAX_DIM  = 64;

  localparam int ACTION_W = 2;
  localparam int ROW_W    = 16;
  localparam int COL_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 2;

  localparam int ROWS_REG_W = 11;
  localparam int DIM_REG_W  = 7;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;

  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 40;

  localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd1024;
  localparam logic [DIM_REG_W-1:0]  DIM_RESET  = 7'd64;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ACCUM  = 2'd0,
    ACT_READ   = 2'd1,
    ACT_CLEAR  = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_ROW = 2'd1,
    ST_BAD_COL = 2'd2,
    ST_SPARE   = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS = 1'd0,
    REG_DIM  = 1'd1
  } reg_index_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_MODIFY
  } state_t;

endpackage

// File: rtl/core/embedding_grad_scatter_add.sv
// Embedding gradient accumulator. Each input beat on the s_axis side is one action:
// accumulate adds grad_value into the word at (row_index, column) with saturation to
// the signed Q16.16 range, read returns that word, and clear zeroes the whole store.
// Every beat yields exactly one result beat carrying a status and the read value.
// Accumulate, read and unused actions: the idle state reads the store as the beat
// is accepted, and the modify state, once the output register is free, writes back
// the saturated sum of an accumulate and loads the output register, so a following
// beat never overlaps the same word. Clear and reset both run a clearing pass that writes
// one word per cycle through all MAX_ROWS*MAX_DIM words (65536 by default), during
// which no beat is accepted; a clear returns its result after that pass. Configuration
// writes are taken at any time and apply to beats accepted afterwards.
module embedding_grad_scatter_add #(
  parameter int MAX_ROWS = egsa_pkg::DEF_MAX_ROWS,
  parameter int MAX_DIM  = egsa_pkg::DEF_MAX_DIM
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // action[1:0], row_index[17:2], column[25:18], grad_value[57:26], zero pad
  input  logic [egsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // status[1:0], read_value[33:2], zero pad
  output logic [egsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input  logic                               cfg_we,
  input  logic [egsa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [egsa_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import egsa_pkg::*;

  localparam int DEPTH       = MAX_ROWS * MAX_DIM;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ADDR_FULL_W = 26;
  localparam int ROW_CMP_W   = 17;
  localparam int COL_CMP_W   = 9;

  logic [ROWS_REG_W-1:0] rows_in_use;
  logic [DIM_REG_W-1:0]  dim_in_use;

  state_t state;
  state_t state_next;

  logic [ADDR_W-1:0] sweep_addr;
  logic              sweep_last;
  logic              clr_resp;

  action_t           act_q;
  status_t           status_q;
  logic [ADDR_W-1:0] addr_q;
  logic [WORD_W-1:0] grad_q;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;

  logic              out_valid;
  status_t           out_status;
  logic [WORD_W-1:0] out_value;

  action_t              in_action;
  logic [ROW_W-1:0]     in_row;
  logic [COL_W-1:0]     in_col;
  logic [WORD_W-1:0]    in_grad;
  logic                 in_fire;
  logic [ROW_CMP_W-1:0] row_ext;
  logic [COL_CMP_W-1:0] col_ext;
  logic                 row_bad;
  logic                 col_bad;
  status_t              in_status;
  logic [ADDR_FULL_W-1:0] addr_full;
  logic [ADDR_W-1:0]    rd_addr;

  logic              out_free;
  logic              load_out;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [WORD_W:0]   sum;
  logic [WORD_W-1:0] sat_sum;

  assign in_action = action_t'(s_axis_tdata[1:0]);
  assign in_row    = s_axis_tdata[17:2];
  assign in_col    = s_axis_tdata[25:18];
  assign in_grad   = s_axis_tdata[57:26];

  assign s_axis_tready = (state == S_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign row_ext = {1'b0, in_row};
  assign col_ext = {1'b0, in_col};
  assign row_bad = in_row[ROW_W-1] || (row_ext >= ROW_CMP_W'(rows_in_use)) ||
                   (row_ext >= ROW_CMP_W'(MAX_ROWS));
  assign col_bad = (col_ext >= COL_CMP_W'(dim_in_use)) || (col_ext >= COL_CMP_W'(MAX_DIM));

  always_comb begin
    in_status = ST_OK;
    if (in_action == ACT_ACCUM || in_action == ACT_READ) begin
      if (row_bad) begin
        in_status = ST_BAD_ROW;
      end else if (col_bad) begin
        in_status = ST_BAD_COL;
      end
    end
  end

  assign addr_full = ADDR_FULL_W'(in_row) * ADDR_FULL_W'(MAX_DIM) + ADDR_FULL_W'(in_col);
  assign rd_addr   = addr_full[ADDR_W-1:0];

  assign sweep_last = (sweep_addr == ADDR_W'(DEPTH - 1));
  assign out_free   = !out_valid || m_axis_tready;

  assign sum     = {rd_data[WORD_W-1], rd_data} + {grad_q[WORD_W-1], grad_q};
  assign sat_sum = (sum[WORD_W] != sum[WORD_W-1]) ?
                   {sum[WORD_W], {(WORD_W-1){~sum[WORD_W]}}} : sum[WORD_W-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_SWEEP: begin
        if (sweep_last) begin
          state_next = clr_resp ? S_MODIFY : S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          state_next = (in_action == ACT_CLEAR) ? S_SWEEP : S_MODIFY;
        end
      end
      S_MODIFY: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_SWEEP;
    endcase
  end

  always_comb begin
    load_out  = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = addr_q;
    mem_wdata = sat_sum;
    case (state)
      S_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr;
        mem_wdata = '0;
      end
      S_MODIFY: begin
        load_out = out_free;
        mem_we   = out_free && (act_q == ACT_ACCUM) && (status_q == ST_OK);
      end
      default: begin
        load_out = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= ROWS_RESET;
      dim_in_use  <= DIM_RESET;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_ROWS: rows_in_use <= cfg_data[ROWS_REG_W-1:0];
        REG_DIM:  dim_in_use  <= cfg_data[DIM_REG_W-1:0];
        default:  rows_in_use <= rows_in_use;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      sweep_addr <= '0;
      clr_resp   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_SWEEP) begin
        sweep_addr <= sweep_addr + ADDR_W'(1);
      end
      if (in_fire && in_action == ACT_CLEAR) begin
        sweep_addr <= '0;
        clr_resp   <= 1'b1;
      end else if (load_out) begin
        clr_resp <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      act_q    <= in_action;
      status_q <= in_status;
      addr_q   <= rd_addr;
      grad_q   <= in_grad;
    end
    if (load_out) begin
      out_status <= status_q;
      out_value  <= (act_q == ACT_READ && status_q == ST_OK) ? rd_data : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_fire) begin
      rd_data <= mem[rd_addr];
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W - WORD_W - STATUS_W){1'b0}}, out_value, out_status};

  a_fire_to_modify: assert property (@(posedge clk) disable iff (rst)
    (in_fire && in_action != ACT_CLEAR) |=> (state == S_MODIFY))
    else $error("Accepted beat did not move to the modify cycle.");

  a_write_phase: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == S_SWEEP || state == S_MODIFY))
    else $error("Store written outside a sweep or modify cycle.");

  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_MODIFY))
    else $error("Result appeared without a modify cycle.");

  a_flagged_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_status != ST_OK) |-> (out_value == '0))
    else $error("Flagged result carries a nonzero value.");

endmodule
